// File: sv/vcg_pkg.sv
// vcg_pkg: shared constants, stage structs and result type for the VHD CHS geometry block.
// No dependencies; every other file of the block imports it.
package vcg_pkg;

  // Field widths
  localparam int SECTORS_W = 48;
  localparam int CYL_W     = 16;
  localparam int HEADS_W   = 5;
  localparam int SPT_W     = 8;

  // Clamped sector count fits 28 bits (65535*16*255 < 2**28)
  localparam int TOTAL_W   = 28;
  // Quotients of the clamped count by 17 or more fit 24 bits
  localparam int CQUO_W    = 24;
  // Selected cylinders-times-heads is at most 65535*16
  localparam int CXH_W     = 20;
  // Remainder of a division by a head count of at most 16
  localparam int HREM_W    = 4;

  localparam logic [SECTORS_W-1:0] CAP_SECTORS = 48'd267382800;  // 65535*16*255
  localparam logic [SECTORS_W-1:0] BIG_SECTORS = 48'd66059280;   // 65535*16*63

  // Constant divisor lanes
  localparam int NUM_DIV = 4;
  localparam int L17  = 0;
  localparam int L31  = 1;
  localparam int L63  = 2;
  localparam int L255 = 3;

  // Scaled reciprocals: ceil(2**shift / divisor). Each rounding error times 2**28
  // stays below 2**shift, so (count * recip) >> shift is exact for counts below 2**28.
  localparam int RECIP_W = 29;
  localparam int PROD_W  = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP [NUM_DIV] =
    '{29'd505290271, 29'd277094665, 29'd272696337, 29'd269488145};
  localparam int RECIP_SHIFT [NUM_DIV] = '{33, 33, 34, 36};

  localparam logic [SPT_W-1:0]   SPT_17    = 8'd17;
  localparam logic [SPT_W-1:0]   SPT_31    = 8'd31;
  localparam logic [SPT_W-1:0]   SPT_63    = 8'd63;
  localparam logic [SPT_W-1:0]   SPT_255   = 8'd255;
  localparam logic [HEADS_W-1:0] MIN_HEADS = 5'd4;
  localparam logic [HEADS_W-1:0] MAX_HEADS = 5'd16;
  localparam int                 HEAD_SHIFT = 10;    // heads * 1024
  localparam int                 HEAD_ROUND = 1023;
  // cylinders-times-heads limit for 16 heads: 16*1024
  localparam logic [CQUO_W-1:0]  CXH16_LIMIT = 24'd16384;

  // State carried through the constant division stage
  typedef struct packed {
    logic                               valid;
    logic                               big;
    logic [TOTAL_W-1:0]                 num;
    logic [NUM_DIV-1:0][CQUO_W-1:0]     quo;
  } cd_t;

  // State carried through the head divider chain
  typedef struct packed {
    logic               valid;
    logic [CXH_W-1:0]   num;
    logic [HREM_W-1:0]  rem;
    logic [CYL_W-1:0]   quo;
    logic [HEADS_W-1:0] heads;
    logic [SPT_W-1:0]   spt;
  } hd_t;

  // Finished geometry
  typedef struct packed {
    logic [CYL_W-1:0]   cylinders;
    logic [HEADS_W-1:0] head_count;
    logic [SPT_W-1:0]   track_sectors;
  } res_t;

endpackage

// File: sv/vcg_in_if.sv
// vcg_in_if: request channel carrying a sector count, valid/ready handshake.
// Depends on vcg_pkg for the field width.
interface vcg_in_if;
  import vcg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SECTORS_W-1:0] disk_sectors;

  modport source (output valid, output disk_sectors, input ready);
  modport sink   (input valid, input disk_sectors, output ready);
endinterface

// File: sv/vcg_out_if.sv
// vcg_out_if: result channel carrying one CHS geometry, valid/ready handshake.
// Depends on vcg_pkg for the field widths.
interface vcg_out_if;
  import vcg_pkg::*;

  logic               valid;
  logic               ready;
  logic [CYL_W-1:0]   cylinders;
  logic [HEADS_W-1:0] head_count;
  logic [SPT_W-1:0]   track_sectors;

  modport source (output valid, output cylinders, output head_count,
                  output track_sectors, input ready);
  modport sink   (input valid, input cylinders, input head_count,
                  input track_sectors, output ready);
endinterface

// File: sv/vcg_cdiv_cell.sv
// vcg_cdiv_cell: one stage dividing the clamped sector count by 17, 31, 63 and 255.
// Depends on vcg_pkg (cd_t, RECIP, RECIP_SHIFT).
module vcg_cdiv_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  vcg_pkg::cd_t d,
  output vcg_pkg::cd_t q
);
  import vcg_pkg::*;

  cd_t q_next;

  // Each quotient is a multiply by the scaled reciprocal and a fixed shift
  always_comb begin
    logic [PROD_W-1:0] prod;
    q_next = d;
    for (int k = 0; k < NUM_DIV; k++) begin
      prod          = PROD_W'(d.num) * PROD_W'(RECIP[k]);
      q_next.quo[k] = CQUO_W'(prod >> RECIP_SHIFT[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule

// File: sv/vcg_pick.sv
// vcg_pick: chooses sectors per track and heads from the quotients, loads the head divider.
// Depends on vcg_pkg (cd_t, hd_t, geometry constants).
module vcg_pick (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  vcg_pkg::cd_t d,
  output vcg_pkg::hd_t q
);
  import vcg_pkg::*;

  localparam int EST_W = CQUO_W + 1 - HEAD_SHIFT;

  logic [CQUO_W-1:0]          q17;
  logic [CQUO_W:0]            est_sum;
  logic [EST_W-1:0]           est;
  logic [EST_W-1:0]           heads17;
  logic                       fall17;
  logic                       fall31;
  hd_t                        q_next;

  // Head estimate for 17 sectors: ceil(cxh/1024), at least 4, kept at full width
  assign q17     = d.quo[L17];
  assign est_sum = {1'b0, q17} + (CQUO_W+1)'(HEAD_ROUND);
  assign est     = est_sum[CQUO_W:HEAD_SHIFT];
  assign heads17 = (est < EST_W'(MIN_HEADS)) ? EST_W'(MIN_HEADS) : est;

  assign fall17 = ({1'b0, q17} >= {heads17, HEAD_SHIFT'(0)})
               || (heads17 > EST_W'(MAX_HEADS));
  assign fall31 = (d.quo[L31] >= CXH16_LIMIT);

  always_comb begin
    q_next.valid = d.valid;
    q_next.rem   = '0;
    q_next.quo   = '0;
    if (d.big) begin
      q_next.spt   = SPT_255;
      q_next.heads = MAX_HEADS;
      q_next.num   = d.quo[L255][CXH_W-1:0];
    end else if (!fall17) begin
      q_next.spt   = SPT_17;
      q_next.heads = heads17[HEADS_W-1:0];
      q_next.num   = q17[CXH_W-1:0];
    end else if (!fall31) begin
      q_next.spt   = SPT_31;
      q_next.heads = MAX_HEADS;
      q_next.num   = d.quo[L31][CXH_W-1:0];
    end else begin
      q_next.spt   = SPT_63;
      q_next.heads = MAX_HEADS;
      q_next.num   = d.quo[L63][CXH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule

// File: sv/vcg_hdiv_cell.sv
// vcg_hdiv_cell: one restoring-division step of cylinders-times-heads by the head count.
// Depends on vcg_pkg (hd_t).
module vcg_hdiv_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  vcg_pkg::hd_t d,
  output vcg_pkg::hd_t q
);
  import vcg_pkg::*;

  hd_t q_next;

  // Remainder stays below heads (at most 16), so it fits four bits
  always_comb begin
    logic [HREM_W:0] r;
    q_next = d;
    r = {d.rem, d.num[CXH_W-1]};
    if (r >= d.heads) begin
      q_next.rem = HREM_W'(r - d.heads);
      q_next.quo = {d.quo[CYL_W-2:0], 1'b1};
    end else begin
      q_next.rem = r[HREM_W-1:0];
      q_next.quo = {d.quo[CYL_W-2:0], 1'b0};
    end
    q_next.num = {d.num[CXH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule

// File: sv/vhd_chs_geometry.sv
// vhd_chs_geometry: sector count to VHD cylinder/head/sector geometry, pipelined cell chain.
// Depends on vcg_pkg, vcg_in_if, vcg_out_if, vcg_cdiv_cell, vcg_pick, vcg_hdiv_cell.
//
//   channel   | dir | payload                                              | handshake
//   ----------+-----+------------------------------------------------------+-----------
//   sectors   | in  | disk_sectors[47:0]                                   | valid/ready
//   geometry  | out | cylinders[15:0] head_count[4:0] track_sectors[7:0]   | valid/ready
//
// One request enters per cycle while the output queue has room; it is registered at the
// accepting edge, then passes the constant-division stage, the selection stage, 20
// head-division cells and the output queue.
// The whole chain advances together whenever the two-entry output queue is not full;
// ready comes from the queue count, so intake stalls only while both entries are held.
// Reset clears the valid bits of every stage and empties the queue; nothing else.
module vhd_chs_geometry (
  input logic       clk,
  input logic       rst,
  vcg_in_if.sink    sectors,
  vcg_out_if.source geometry
);
  import vcg_pkg::*;

  cd_t        cd [2];
  hd_t        hd [CXH_W+1];
  logic       adv;
  res_t       slot [2];
  logic [1:0] count;
  logic       push;
  logic       pop;
  res_t       fresh;

  // Chain moves whenever the queue can take one more result
  assign adv           = (count != 2'd2);
  assign sectors.ready = adv;

  // Input stage: clamp the count and flag large disks
  always_ff @(posedge clk) begin
    if (rst) begin
      cd[0].valid <= 1'b0;
    end else if (adv) begin
      cd[0].valid <= sectors.valid;
      cd[0].big   <= (sectors.disk_sectors >= BIG_SECTORS);
      cd[0].num   <= (sectors.disk_sectors > CAP_SECTORS) ? CAP_SECTORS[TOTAL_W-1:0]
                                                          : sectors.disk_sectors[TOTAL_W-1:0];
      cd[0].quo   <= '0;
    end
  end

  // Divide by 17, 31, 63 and 255 in one stage
  vcg_cdiv_cell u_cdiv (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (cd[0]),
    .q   (cd[1])
  );

  vcg_pick u_pick (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (cd[1]),
    .q   (hd[0])
  );

  // Divide cylinders-times-heads by heads, one quotient bit per cell
  for (genvar j = 0; j < CXH_W; j++) begin : g_hdiv
    vcg_hdiv_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (hd[j]),
      .q   (hd[j+1])
    );
  end

  // Output queue, two entries, slot 0 is the head
  assign fresh.cylinders     = hd[CXH_W].quo;
  assign fresh.head_count    = hd[CXH_W].heads;
  assign fresh.track_sectors = hd[CXH_W].spt;

  assign push = hd[CXH_W].valid && adv;
  assign pop  = geometry.valid && geometry.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot[0] <= fresh;
        end else begin
          slot[1] <= fresh;
        end
      end
      2'b01: begin
        slot[0] <= slot[1];
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot[0] <= fresh;
        end else begin
          slot[0] <= slot[1];
          slot[1] <= fresh;
        end
      end
      default: begin
      end
    endcase
  end

  assign geometry.valid         = (count != 2'd0);
  assign geometry.cylinders     = slot[0].cylinders;
  assign geometry.head_count    = slot[0].head_count;
  assign geometry.track_sectors = slot[0].track_sectors;
endmodule

// File: tb/sv/tb_vhd_chs_geometry.sv
// tb_vhd_chs_geometry: self-checking bench for the VHD CHS geometry block, with an in-bench
// geometry predictor, random request/result idling, a long result hold-off and drain pauses.
// Depends on vcg_pkg, vcg_in_if, vcg_out_if and vhd_chs_geometry.
module tb_vhd_chs_geometry;
  timeunit 1ns;
  timeprecision 1ps;
  import vcg_pkg::*;

  localparam longint unsigned HEAD_SPAN = 1024;

  logic clk = 1'b0;
  logic rst;

  vcg_in_if  sectors_bus ();
  vcg_out_if geometry_bus ();

  vhd_chs_geometry u_top (
    .clk      (clk),
    .rst      (rst),
    .sectors  (sectors_bus),
    .geometry (geometry_bus)
  );

  always #6 clk = ~clk;

  res_t        geom_pending[$];
  res_t        rx_want;
  int unsigned n_fail;
  int unsigned n_checked;
  int unsigned n_spt17, n_spt31, n_spt63, n_spt255;
  bit          steady;     // both sides run without gaps while set
  int unsigned hold_req;   // request for a long result hold-off, in cycles
  int unsigned rx_stall;
  int unsigned rx_gap;

  // Geometry expected for one sector count
  function automatic res_t chs_of_count(input logic [SECTORS_W-1:0] count);
    longint unsigned total;
    longint unsigned cxh;
    longint unsigned heads;
    longint unsigned spt;
    res_t            geo;
    total = count;
    if (total > CAP_SECTORS) total = CAP_SECTORS;
    if (total >= BIG_SECTORS) begin
      spt   = SPT_255;
      heads = MAX_HEADS;
      cxh   = total / spt;
    end else begin
      spt   = SPT_17;
      cxh   = total / spt;
      heads = (cxh + HEAD_ROUND) / HEAD_SPAN;
      if (heads < MIN_HEADS) heads = MIN_HEADS;
      // full-width head estimate: above 16 always falls back
      if (cxh >= heads * HEAD_SPAN || heads > MAX_HEADS) begin
        spt   = SPT_31;
        heads = MAX_HEADS;
        cxh   = total / spt;
      end
      // 63 is final even if it still does not fit
      if (cxh >= heads * HEAD_SPAN) begin
        spt   = SPT_63;
        heads = MAX_HEADS;
        cxh   = total / spt;
      end
    end
    geo.cylinders     = CYL_W'(cxh / heads);
    geo.head_count    = HEADS_W'(heads);
    geo.track_sectors = SPT_W'(spt);
    return geo;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random sector count, weighted toward the interesting ranges
  function automatic logic [SECTORS_W-1:0] rand_count();
    int unsigned     r;
    int unsigned     k;
    longint unsigned base;
    r = $urandom_range(0, 99);
    if (r < 10) return {16'($urandom_range(0, 65535)), 32'($urandom)};
    if (r < 20) return SECTORS_W'($urandom_range(0, 200000));
    if (r < 40) begin
      // around a switch point of heads or sectors per track
      k = $urandom_range(4, 19);
      if (k <= 17)      base = 17 * HEAD_SPAN * k;
      else if (k == 18) base = 31 * HEAD_SPAN * 16;
      else              base = $urandom_range(0, 1) ? BIG_SECTORS : CAP_SECTORS;
      return SECTORS_W'(base + $urandom_range(0, 128) - 64);
    end
    return SECTORS_W'($urandom_range(0, 32'(CAP_SECTORS) + 1000));
  endfunction

  // Offer one sector count and hold it until accepted
  task automatic send_count(input logic [SECTORS_W-1:0] count);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      sectors_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sectors_bus.valid        <= 1'b1;
    sectors_bus.disk_sectors <= count;
    @(posedge clk);
    while (!sectors_bus.ready) @(posedge clk);
    geom_pending.push_back(chs_of_count(count));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    sectors_bus.valid <= 1'b0;
    do @(posedge clk); while (geom_pending.size() != 0);
  endtask

  task automatic test_directed();
    logic [SECTORS_W-1:0] edge_counts[$];
    edge_counts = '{
      48'd0, 48'd1, 48'd16, 48'd17,
      48'd69631, 48'd69632, 48'd69649,            // 17 spt: 4 heads limit
      48'd278527, 48'd278528, 48'd278545,         // 17 spt: 16 heads limit, estimate of 17
      48'd507903, 48'd507904,                     // 31 spt limit
      BIG_SECTORS - 1, BIG_SECTORS, BIG_SECTORS + 1,
      CAP_SECTORS - 1, CAP_SECTORS, CAP_SECTORS + 1,
      48'h1000_0000, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
      48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h0000_FFFF_FFFF
    };
    foreach (edge_counts[i]) send_count(edge_counts[i]);
    wait_drained();
  endtask

  // Back-to-back requests with the result side always ready
  task automatic test_full_rate();
    steady = 1'b1;
    repeat (200) send_count(rand_count());
    steady = 1'b0;
    wait_drained();
  endtask

  // Long result hold-off while requests keep coming, so intake stalls
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = 300;
    repeat (150) send_count(rand_count());
    steady = 1'b0;
    wait_drained();
  endtask

  // Random traffic with idle stretches, calm stretches and drain pauses
  task automatic test_random();
    for (int i = 0; i < 1530; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_count(rand_count());
      if (i % 400 == 399) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  // Result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      geometry_bus.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      geometry_bus.ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else if (hold_req != 0) begin
      geometry_bus.ready <= 1'b0;
      rx_stall = hold_req - 1;
      hold_req = 0;
    end else if (steady) begin
      geometry_bus.ready <= 1'b1;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap == 0) begin
        geometry_bus.ready <= 1'b1;
      end else begin
        geometry_bus.ready <= 1'b0;
        rx_stall = rx_gap - 1;
      end
    end
  end

  // Compare each accepted geometry with the oldest prediction
  always @(posedge clk) begin
    if (!rst && geometry_bus.valid && geometry_bus.ready) begin
      if (geom_pending.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected geometry, expected none, actual %0d/%0d/%0d", $time,
                 geometry_bus.cylinders, geometry_bus.head_count,
                 geometry_bus.track_sectors);
      end else begin
        rx_want = geom_pending.pop_front();
        n_checked++;
        if (geometry_bus.cylinders !== rx_want.cylinders) begin
          n_fail++;
          $display("%0t: cylinders expected %0d actual %0d", $time,
                   rx_want.cylinders, geometry_bus.cylinders);
        end
        if (geometry_bus.head_count !== rx_want.head_count) begin
          n_fail++;
          $display("%0t: head_count expected %0d actual %0d", $time,
                   rx_want.head_count, geometry_bus.head_count);
        end
        if (geometry_bus.track_sectors !== rx_want.track_sectors) begin
          n_fail++;
          $display("%0t: track_sectors expected %0d actual %0d", $time,
                   rx_want.track_sectors, geometry_bus.track_sectors);
        end
        case (rx_want.track_sectors)
          SPT_17:  n_spt17++;
          SPT_31:  n_spt31++;
          SPT_63:  n_spt63++;
          default: n_spt255++;
        endcase
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst                      = 1'b1;
    sectors_bus.valid        = 1'b0;
    sectors_bus.disk_sectors = '0;
    geometry_bus.ready       = 1'b0;
    steady                   = 1'b0;
    hold_req                 = 0;
    rx_stall                 = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();

    // let any stray result show up
    repeat (60) @(posedge clk);
    if (geom_pending.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected geometries never arrived", $time, geom_pending.size());
    end
    $display("%0d geometries checked across full-rate, hold-off and random traffic",
             n_checked);
    $display("sectors per track seen: 17 x%0d, 31 x%0d, 63 x%0d, 255 x%0d",
             n_spt17, n_spt31, n_spt63, n_spt255);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
